// ===== sv/bdq_pkg.sv =====
// shared types and constants for the bounded deque with reverse and swap
// no dependencies; used by bdq_ctrl and bounded_deque_with_reverse_swap
`default_nettype none

package bdq_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned PTR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = PTR_W + 1;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VALUE_W  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_REVERSE    = 3'd3,
    OP_SWAP       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [PTR_W-1:0]          pos_a;
    logic [PTR_W-1:0]          pos_b;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    logic                      popped_valid;
    logic [STATUS_W-1:0]       status;
    logic [CNT_W-1:0]          element_count;
    logic                      is_empty;
  } resp_t;

  // what the pointer logic asks of the datapath for one request
  typedef struct packed {
    logic [PTR_W-1:0]    rd_addr_a;
    logic [PTR_W-1:0]    rd_addr_b;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic                pop;
    logic                swap;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
  } plan_t;

endpackage

`default_nettype wire

// ===== sv/bdq_ram.sv =====
// generic ram: one write port, two read ports with registered read data
// no dependencies
`default_nettype none

module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== sv/bdq_ctrl.sv =====
// ring pointer state: front index, element count, direction flag
// depends on bdq_pkg; turns each request into ram accesses and a status
`default_nettype none

module bdq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire bdq_pkg::req_t req_i,
  output bdq_pkg::plan_t     plan_o
);

  logic [bdq_pkg::PTR_W-1:0] front_q, front_d;
  logic [bdq_pkg::CNT_W-1:0] count_q, count_d;
  logic                      rev_q, rev_d;

  logic [bdq_pkg::CNT_W-1:0] count_m1;
  logic [bdq_pkg::PTR_W-1:0] back_addr;
  logic [bdq_pkg::PTR_W-1:0] swap_addr_a;
  logic [bdq_pkg::PTR_W-1:0] swap_addr_b;
  logic [bdq_pkg::PTR_W-1:0] front_fwd;
  logic [bdq_pkg::PTR_W-1:0] front_bwd;
  logic                      range_bad;

  // ring arithmetic wraps naturally at the power-of-two depth
  assign count_m1    = count_q - bdq_pkg::CNT_W'(1);
  assign back_addr   = rev_q ? front_q - count_m1[bdq_pkg::PTR_W-1:0]
                             : front_q + count_m1[bdq_pkg::PTR_W-1:0];
  assign swap_addr_a = rev_q ? front_q - req_i.pos_a : front_q + req_i.pos_a;
  assign swap_addr_b = rev_q ? front_q - req_i.pos_b : front_q + req_i.pos_b;
  // one step toward the back, and one step out past the front
  assign front_fwd   = rev_q ? front_q - bdq_pkg::PTR_W'(1) : front_q + bdq_pkg::PTR_W'(1);
  assign front_bwd   = rev_q ? front_q + bdq_pkg::PTR_W'(1) : front_q - bdq_pkg::PTR_W'(1);
  assign range_bad   = ({1'b0, req_i.pos_a} >= count_q) || ({1'b0, req_i.pos_b} >= count_q);

  always_comb begin
    front_d          = front_q;
    count_d          = count_q;
    rev_d            = rev_q;
    plan_o.rd_addr_a = front_q;
    plan_o.rd_addr_b = front_q;
    plan_o.wr_en     = 1'b0;
    plan_o.wr_addr   = front_q;
    plan_o.pop       = 1'b0;
    plan_o.swap      = 1'b0;
    plan_o.status    = bdq_pkg::ST_OK;
    unique case (req_i.op)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (count_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH)) begin
          plan_o.status = bdq_pkg::ST_FULL;
        end else begin
          if (count_q != '0) begin
            front_d = front_bwd;
          end
          plan_o.wr_en   = 1'b1;
          plan_o.wr_addr = front_d;
          count_d        = count_q + bdq_pkg::CNT_W'(1);
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (count_q == '0) begin
          plan_o.status = bdq_pkg::ST_EMPTY;
        end else begin
          plan_o.rd_addr_a = front_q;
          plan_o.pop       = 1'b1;
          count_d          = count_m1;
          if (count_m1 != '0) begin
            front_d = front_fwd;
          end
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (count_q == '0) begin
          plan_o.status = bdq_pkg::ST_EMPTY;
        end else begin
          plan_o.rd_addr_a = back_addr;
          plan_o.pop       = 1'b1;
          count_d          = count_m1;
        end
      end
      bdq_pkg::OP_REVERSE: begin
        if (count_q > bdq_pkg::CNT_W'(1)) begin
          front_d = back_addr;
          rev_d   = ~rev_q;
        end
      end
      bdq_pkg::OP_SWAP: begin
        if (range_bad) begin
          plan_o.status = bdq_pkg::ST_RANGE;
        end else begin
          plan_o.rd_addr_a = swap_addr_a;
          plan_o.rd_addr_b = swap_addr_b;
          plan_o.swap      = 1'b1;
        end
      end
      bdq_pkg::OP_CLEAR: begin
        front_d = '0;
        count_d = '0;
        rev_d   = 1'b0;
      end
      default: begin
      end
    endcase
    plan_o.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
    end else if (accept_i) begin
      front_q <= front_d;
      count_q <= count_d;
      rev_q   <= rev_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bounded_deque_with_reverse_swap.sv =====
// the result beat appears in the cycle after the request is taken
// throughput: one request per cycle while busy is low; a swap keeps busy
//   high until its two write-backs to the single ram write port are done
// reset: front index, count and direction flag clear at once; ram contents
//   stay undefined and need no clearing pass; the receiver cannot stall
`default_nettype none

module bounded_deque_with_reverse_swap #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire bdq_pkg::req_t req_i,
  output logic               result_valid_o,
  output bdq_pkg::resp_t     result_o
);

  // request accepted this cycle
  logic accept;

  // plan from the pointer logic for the request on the inputs
  bdq_pkg::plan_t plan;

  // ring ram ports
  logic                      ram_we;
  logic [bdq_pkg::PTR_W-1:0] ram_waddr;
  logic [DATA_WIDTH-1:0]     ram_wdata;
  logic [DATA_WIDTH-1:0]     ram_rdata_a;
  logic [DATA_WIDTH-1:0]     ram_rdata_b;

  // width adaptation between the 32-bit fields and the stored word
  logic [DATA_WIDTH+bdq_pkg::VALUE_W-1:0] push_ext;
  logic [DATA_WIDTH-1:0]                  push_data;
  logic [DATA_WIDTH+bdq_pkg::VALUE_W-1:0] pop_ext;

  // result stage, lines up with the registered ram read data
  logic                         s1_valid_q;
  logic                         s1_swap_q;
  logic                         s1_pop_q;
  logic [bdq_pkg::STATUS_W-1:0] s1_status_q;
  logic [bdq_pkg::CNT_W-1:0]    s1_count_q;
  logic [bdq_pkg::PTR_W-1:0]    s1_addr_a_q;
  logic [bdq_pkg::PTR_W-1:0]    s1_addr_b_q;

  // second write-back of a swap
  logic                         s2_valid_q;
  logic [bdq_pkg::PTR_W-1:0]    s2_addr_q;
  logic [DATA_WIDTH-1:0]        s2_data_q;

  logic swap_wb1;

  assign swap_wb1 = s1_valid_q && s1_swap_q;

  // a swap owns the write port until both of its write-backs are done
  assign busy   = swap_wb1 || s2_valid_q;
  assign accept = start && !busy;

  bdq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .plan_o   (plan)
  );

  // push value keeps its low bits, or is zero-extended into a wider word
  assign push_ext  = {{DATA_WIDTH{1'b0}}, req_i.value};
  assign push_data = push_ext[DATA_WIDTH-1:0];

  // write port: a push writes when taken; a swap writes back from s1, then
  // s2 (no request is taken then, so the sources never collide)
  always_comb begin
    priority if (swap_wb1) begin
      ram_we    = 1'b1;
      ram_waddr = s1_addr_a_q;
      ram_wdata = ram_rdata_b;
    end else if (s2_valid_q) begin
      ram_we    = 1'b1;
      ram_waddr = s2_addr_q;
      ram_wdata = s2_data_q;
    end else begin
      ram_we    = accept && plan.wr_en;
      ram_waddr = plan.wr_addr;
      ram_wdata = push_data;
    end
  end

  bdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (bdq_pkg::DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (plan.rd_addr_a),
    .raddr_b_i (plan.rd_addr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // control of the result and write-back stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_swap_q  <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s1_swap_q  <= accept && plan.swap;
      s2_valid_q <= swap_wb1;
    end
  end

  // payload of the stages, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pop_q    <= plan.pop;
      s1_status_q <= plan.status;
      s1_count_q  <= plan.count;
      s1_addr_a_q <= plan.rd_addr_a;
      s1_addr_b_q <= plan.rd_addr_b;
    end
    if (swap_wb1) begin
      // old value of the first position goes to the second position
      s2_addr_q <= s1_addr_b_q;
      s2_data_q <= ram_rdata_a;
    end
  end

  // popped word back to the 32-bit field, zero-extended when narrower
  assign pop_ext = {{bdq_pkg::VALUE_W{1'b0}}, ram_rdata_a};

  // result beat: one cycle per accepted request
  assign result_valid_o         = s1_valid_q;
  assign result_o.popped_value  = s1_pop_q ? pop_ext[bdq_pkg::VALUE_W-1:0]
                                           : '0;
  assign result_o.popped_valid  = s1_pop_q;
  assign result_o.status        = s1_status_q;
  assign result_o.element_count = s1_count_q;
  assign result_o.is_empty      = (s1_count_q == '0);

  // every accepted request yields exactly one result beat next cycle
  a_accept_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("accepted request produced no result beat");

  // the second write-back only ever follows the first one
  a_swap_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> $past(swap_wb1))
    else $error("swap second write-back without first");

  // nothing is taken during the first write-back of a swap
  a_swap_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    swap_wb1 |=> !result_valid_o)
    else $error("result beat during swap write-back");

  // a pop that returns data always reports ok, and count stays in range
  a_result_sane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!result_o.popped_valid || result_o.status == bdq_pkg::ST_OK)
                       && (result_o.element_count <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH)))
    else $error("inconsistent result beat");

endmodule

`default_nettype wire

// ===== bench/bounded_deque_with_reverse_swap_tb.sv =====
// self-checking bench for bounded_deque_with_reverse_swap: directed corner beats, then
// random op mixes checked against a cycle-free deque predictor; depends on bdq_pkg
`default_nettype none

module bounded_deque_with_reverse_swap_tb;

  // op codes the block leaves unused, still legal on the wire
  localparam logic [bdq_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [bdq_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_BEATS = 1450;
  localparam int PHASE_BEATS  = 50;
  localparam int STALL_LIMIT  = 200;
  localparam int DRAIN_CYCLES = 4;

  // predicts one response per request and checks responses in order
  class deque_tracker;
    logic [bdq_pkg::VALUE_W-1:0] slots [bdq_pkg::DEPTH];
    logic [bdq_pkg::PTR_W-1:0]   front = '0;
    logic [bdq_pkg::CNT_W-1:0]   count = '0;
    bit                          reversed = 1'b0;
    bdq_pkg::resp_t              expected_resps [$];
    int                          errors = 0;

    // ring address of a position counted from the front
    function logic [bdq_pkg::PTR_W-1:0] ring_pos(logic [bdq_pkg::PTR_W-1:0] pos);
      return reversed ? front - pos : front + pos;
    endfunction

    function void take_request(bdq_pkg::req_t r);
      bdq_pkg::resp_t              e;
      logic [bdq_pkg::PTR_W-1:0]   p;
      logic [bdq_pkg::PTR_W-1:0]   q;
      logic [bdq_pkg::VALUE_W-1:0] t;
      e = '0;
      e.status = bdq_pkg::ST_OK;
      case (r.op)
        bdq_pkg::OP_PUSH_FRONT: begin
          if (count >= bdq_pkg::DEPTH) begin
            e.status = bdq_pkg::ST_FULL;
          end else begin
            // the front moves against the read direction
            if (count != 0) front = reversed ? front + 1'b1 : front - 1'b1;
            slots[front] = r.value;
            count++;
          end
        end
        bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
          if (count == 0) begin
            e.status = bdq_pkg::ST_EMPTY;
          end else begin
            p = (r.op == bdq_pkg::OP_POP_FRONT) ? front
                                                : ring_pos(bdq_pkg::PTR_W'(count - 1'b1));
            e.popped_value = slots[p];
            e.popped_valid = 1'b1;
            count--;
            if (r.op == bdq_pkg::OP_POP_FRONT && count != 0)
              front = reversed ? front - 1'b1 : front + 1'b1;
          end
        end
        bdq_pkg::OP_REVERSE: begin
          // the old back becomes the front and the walk direction flips
          if (count > 1) begin
            front = ring_pos(bdq_pkg::PTR_W'(count - 1'b1));
            reversed = !reversed;
          end
        end
        bdq_pkg::OP_SWAP: begin
          if (r.pos_a >= count || r.pos_b >= count) begin
            e.status = bdq_pkg::ST_RANGE;
          end else begin
            p = ring_pos(r.pos_a);
            q = ring_pos(r.pos_b);
            t = slots[p];
            slots[p] = slots[q];
            slots[q] = t;
          end
        end
        bdq_pkg::OP_CLEAR: begin
          count = '0;
          front = '0;
          reversed = 1'b0;
        end
        default: ;
      endcase
      e.element_count = count;
      e.is_empty = (count == 0);
      expected_resps.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(bdq_pkg::resp_t got);
      bdq_pkg::resp_t e;
      if (expected_resps.size() == 0) begin
        report("result beat with no request outstanding");
        return;
      end
      e = expected_resps.pop_front();
      if (got.popped_value !== e.popped_value)
        report($sformatf("popped_value %0d, expected %0d", got.popped_value,
                         e.popped_value));
      if (got.popped_valid !== e.popped_valid)
        report($sformatf("popped_valid %b, expected %b", got.popped_valid,
                         e.popped_valid));
      if (got.status !== e.status)
        report($sformatf("status %0d, expected %0d", got.status, e.status));
      if (got.element_count !== e.element_count)
        report($sformatf("element_count %0d, expected %0d", got.element_count,
                         e.element_count));
      if (got.is_empty !== e.is_empty)
        report($sformatf("is_empty %b, expected %b", got.is_empty, e.is_empty));
    endtask

    function int pending();
      return expected_resps.size();
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  bdq_pkg::req_t  req_i;
  logic           result_valid_o;
  bdq_pkg::resp_t result_o;

  deque_tracker board;
  bit           idle_on;
  int           stall_cycles;

  bounded_deque_with_reverse_swap dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // every result beat lives for one cycle; sample it at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) board.check_result(result_o);
  end

  // watchdog: any accepted request or result beat resets the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("bounded_deque_with_reverse_swap_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic bdq_pkg::req_t make_req(logic [bdq_pkg::OP_W-1:0]    op,
                                             logic [bdq_pkg::VALUE_W-1:0] value,
                                             logic [bdq_pkg::PTR_W-1:0]   pos_a,
                                             logic [bdq_pkg::PTR_W-1:0]   pos_b);
    bdq_pkg::req_t r;
    r.op = op;
    r.value = value;
    r.pos_a = pos_a;
    r.pos_b = pos_b;
    return r;
  endfunction

  // extremes show up often enough to hit sign and all-ones patterns
  function automatic logic [bdq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // mostly positions inside the store, sometimes anywhere in the field
  function automatic logic [bdq_pkg::PTR_W-1:0] pick_pos();
    if (board.count != 0 && $urandom_range(0, 3) != 0)
      return bdq_pkg::PTR_W'($urandom_range(0, board.count - 1));
    return bdq_pkg::PTR_W'($urandom_range(0, bdq_pkg::DEPTH - 1));
  endfunction

  // phase 0 fills toward full, phase 1 drains toward empty, phase 2 hovers
  function automatic logic [bdq_pkg::OP_W-1:0] pick_op(int phase);
    int push_pct;
    int pop_pct;
    int r;
    push_pct = (phase == 0) ? 60 : (phase == 1) ? 20 : 35;
    pop_pct  = (phase == 0) ? 20 : (phase == 1) ? 55 : 35;
    r = $urandom_range(0, 99);
    if (r < push_pct) return bdq_pkg::OP_PUSH_FRONT;
    if (r < push_pct + pop_pct)
      return $urandom_range(0, 1) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_BACK;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7:        return bdq_pkg::OP_REVERSE;
      8, 9, 10, 11, 12, 13, 14, 15:  return bdq_pkg::OP_SWAP;
      16:                            return bdq_pkg::OP_CLEAR;
      17:                            return OP_SPARE_6;
      18:                            return OP_SPARE_7;
      default:                       return bdq_pkg::OP_POP_BACK;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_beat(bdq_pkg::req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    req_i = r;
    // a swap keeps busy high until its write-backs are done, so wait it out
    do @(posedge clk_i); while (busy);
    board.take_request(r);
    @(negedge clk_i);
  endtask

  initial begin
    bdq_pkg::req_t directed [$];
    int            phase;
    board   = new;
    rst_ni  = 1'b0;
    start   = 1'b0;
    req_i   = '0;
    idle_on = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty-store corners, unused ops, single element cases
    directed.push_back(make_req(bdq_pkg::OP_POP_FRONT, '0, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_POP_BACK, '1, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_REVERSE, '0, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_SWAP, '0, '0, '0));
    directed.push_back(make_req(OP_SPARE_6, '1, '1, '1));
    directed.push_back(make_req(OP_SPARE_7, '0, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_REVERSE, '0, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_SWAP, '0, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_POP_BACK, '0, '0, '0));
    // a few elements, reverse, swap in and out of range, both pops, clear, pop, push
    directed.push_back(make_req(bdq_pkg::OP_PUSH_FRONT, 32'h8000_0000, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_PUSH_FRONT, '0, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_PUSH_FRONT, '1, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_PUSH_FRONT, 32'h5a5a_a5a5, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_REVERSE, '0, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_SWAP, '0, 4'd0, 4'd3));
    directed.push_back(make_req(bdq_pkg::OP_SWAP, '0, 4'd1, 4'd15));
    directed.push_back(make_req(bdq_pkg::OP_SWAP, '0, 4'd15, 4'd1));
    directed.push_back(make_req(bdq_pkg::OP_SWAP, '0, 4'd2, 4'd2));
    directed.push_back(make_req(bdq_pkg::OP_POP_FRONT, '0, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_POP_BACK, '0, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_CLEAR, '0, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_POP_BACK, '0, '0, '0));
    directed.push_back(make_req(bdq_pkg::OP_PUSH_FRONT, 32'h0000_0001, '0, '0));
    foreach (directed[i]) drive_beat(directed[i]);

    // random part: phases of fill, drain and churn, some with no idle gaps
    phase = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % PHASE_BEATS == 0) begin
        phase = $urandom_range(0, 2);
        idle_on = ($urandom_range(0, 3) != 0);
      end
      drive_beat(make_req(pick_op(phase), pick_value(), pick_pos(), pick_pos()));
    end
    start = 1'b0;

    // drain: the watchdog bounds this wait
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("bounded_deque_with_reverse_swap_tb passed");
    end else begin
      $display("bounded_deque_with_reverse_swap_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/bdq_pkg.sv
sv/bdq_ram.sv
sv/bdq_ctrl.sv
sv/bounded_deque_with_reverse_swap.sv
bench/bounded_deque_with_reverse_swap_tb.sv
